[src/pixel_channel_packer_macros.svh]
// Assertion macros for the pixel channel packer.
// Used by pixel_channel_packer.sv; expects clk and rst in scope.
`ifndef PIXEL_CHANNEL_PACKER_MACROS_SVH
`define PIXEL_CHANNEL_PACKER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define PCP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pixel_channel_packer: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define PCP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pixel_channel_packer: next-cycle check failed");

`endif

[src/pcp_pkg.sv]
// Shared types and constants for the pixel channel packer.
// No dependencies; used by pixel_channel_packer.sv and pixel_channel_packer_tb.sv.
package pcp_pkg;

  localparam int CHAN_W       = 8;
  localparam int WORD_W       = 32;
  localparam int NUM_IN_CHANS = 4;
  localparam int CNT_W        = 3;
  localparam int BYTE_IDX_W   = 2;
  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 32;
  localparam int HB_W         = 5;

  localparam int MAX_CHANNELS_DEF = 4;

  // Register reset values
  localparam logic              BYTE_ORDER_RST = 1'b0;
  localparam logic [CNT_W-1:0]  BPP_RST        = 3'd3;
  localparam logic [CNT_W-1:0]  CHAN_CNT_RST   = 3'd3;
  localparam logic [WORD_W-1:0] MASK_0_RST     = 32'h00ff_0000;
  localparam logic [WORD_W-1:0] MASK_1_RST     = 32'h0000_ff00;
  localparam logic [WORD_W-1:0] MASK_2_RST     = 32'h0000_00ff;
  localparam logic [WORD_W-1:0] MASK_3_RST     = 32'h0000_0000;

  // Bit position the channel MSB is aligned from
  localparam logic [HB_W-1:0] CHAN_TOP = 5'd7;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_BYTE_ORDER = 3'd0,
    CFG_BPP        = 3'd1,
    CFG_CHAN_CNT   = 3'd2,
    CFG_MASK_0     = 3'd3,
    CFG_MASK_1     = 3'd4,
    CFG_MASK_2     = 3'd5,
    CFG_MASK_3     = 3'd6
  } cfg_reg_t;

endpackage

[src/pixel_channel_packer.sv]
// Pixel channel packer: places channels under masks and streams the word as bytes.
// Depends on pcp_pkg.sv and pixel_channel_packer_macros.svh.
//
// Channel  Dir  Handshake          Payload (low bit first)
// s_       in   s_tvalid/s_tready  tdata: channel_0..channel_3; tlast: last_pixel
// m_       out  m_tvalid/m_tready  tdata: out_byte; tlast: last_of_pixel;
//                                  tuser: last_of_frame
// cfg_     in   cfg_wr_en          cfg_index, cfg_data
//
// Three register stages (input, placed channels, packed word) feed a byte
// serializer with an output register.
// The serializer sends one byte per cycle while not stalled, so a pixel is sent
// as bytes_per_pixel bytes (clamped to 1 to 4); pixels of one byte stream at one per cycle.
// rst (synchronous) empties the pipeline and loads register reset values.
// A stall on m_tready holds the output and each full stage behind it; nothing is dropped or repeated.
`include "pixel_channel_packer_macros.svh"

module pixel_channel_packer #(
  parameter int MAX_CHANNELS = pcp_pkg::MAX_CHANNELS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // channel_0 [7:0], channel_1 [15:8], channel_2 [23:16], channel_3 [31:24]
  input  logic [pcp_pkg::NUM_IN_CHANS*pcp_pkg::CHAN_W-1:0] s_tdata,
  input  logic                             s_tlast,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // out_byte [7:0]
  output logic [pcp_pkg::CHAN_W-1:0]       m_tdata,
  output logic                             m_tlast,
  // last_of_frame [0]
  output logic [0:0]                       m_tuser,
  input  logic                             cfg_wr_en,
  input  logic [pcp_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [pcp_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int CW = pcp_pkg::CHAN_W;
  localparam int WW = pcp_pkg::WORD_W;
  localparam int NW = pcp_pkg::CNT_W;
  localparam int BW = pcp_pkg::BYTE_IDX_W;

  // Configuration registers
  logic          byte_order;
  logic [NW-1:0] bytes_per_pixel;
  logic [NW-1:0] channel_count;
  logic [WW-1:0] channel_mask [pcp_pkg::NUM_IN_CHANS];

  // Stage 1: captured input
  logic          s1_valid;
  logic [CW-1:0] s1_chan [pcp_pkg::NUM_IN_CHANS];
  logic          s1_last;

  // Stage 2: placed channels
  logic          s2_valid;
  logic [WW-1:0] s2_part [MAX_CHANNELS];
  logic          s2_last;

  // Stage 3: packed word being serialized
  logic          s3_valid;
  logic [WW-1:0] s3_word;
  logic          s3_last;
  logic [BW-1:0] s3_idx;

  logic          out_free;
  logic          s3_final;
  logic          s3_ready;
  logic          s2_ready;
  logic          s1_ready;
  logic [NW-1:0] chans_eff;
  logic [BW-1:0] nb_m1;
  logic [BW-1:0] byte_pos;
  logic [WW-1:0] placed [MAX_CHANNELS];
  logic [WW-1:0] word_or;

  // Shift value so its bit 7 lands on the mask's top bit, then mask it
  function automatic logic [WW-1:0] place_channel(input logic [CW-1:0] v,
                                                  input logic [WW-1:0] m);
    logic [pcp_pkg::HB_W-1:0] hb;
    logic [WW-1:0]            wide;
    logic [WW-1:0]            s;
    hb = '0;
    for (int b = 0; b < WW; b++) begin
      if (m[b]) begin
        hb = pcp_pkg::HB_W'(b);
      end
    end
    wide = {{(WW-CW){1'b0}}, v};
    if (hb >= pcp_pkg::CHAN_TOP) begin
      s = wide << (hb - pcp_pkg::CHAN_TOP);
    end else begin
      s = wide >> (pcp_pkg::CHAN_TOP - hb);
    end
    return s & m;
  endfunction

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_order      <= pcp_pkg::BYTE_ORDER_RST;
      bytes_per_pixel <= pcp_pkg::BPP_RST;
      channel_count   <= pcp_pkg::CHAN_CNT_RST;
      channel_mask[0] <= pcp_pkg::MASK_0_RST;
      channel_mask[1] <= pcp_pkg::MASK_1_RST;
      channel_mask[2] <= pcp_pkg::MASK_2_RST;
      channel_mask[3] <= pcp_pkg::MASK_3_RST;
    end else if (cfg_wr_en) begin
      unique case (pcp_pkg::cfg_reg_t'(cfg_index))
        pcp_pkg::CFG_BYTE_ORDER: byte_order      <= cfg_data[0];
        pcp_pkg::CFG_BPP:        bytes_per_pixel <= cfg_data[NW-1:0];
        pcp_pkg::CFG_CHAN_CNT:   channel_count   <= cfg_data[NW-1:0];
        pcp_pkg::CFG_MASK_0:     channel_mask[0] <= cfg_data[WW-1:0];
        pcp_pkg::CFG_MASK_1:     channel_mask[1] <= cfg_data[WW-1:0];
        pcp_pkg::CFG_MASK_2:     channel_mask[2] <= cfg_data[WW-1:0];
        pcp_pkg::CFG_MASK_3:     channel_mask[3] <= cfg_data[WW-1:0];
        default: ;
      endcase
    end
  end

  // Clamp counts to their legal ranges
  always_comb begin
    if (channel_count > NW'(MAX_CHANNELS)) begin
      chans_eff = NW'(MAX_CHANNELS);
    end else begin
      chans_eff = channel_count;
    end
    if (bytes_per_pixel == '0) begin
      nb_m1 = '0;
    end else if (bytes_per_pixel >= NW'(4)) begin
      nb_m1 = '1;
    end else begin
      nb_m1 = BW'(bytes_per_pixel - NW'(1));
    end
  end

  // Pipeline handshake: a stage advances when the next one can take its word
  assign out_free = !m_tvalid || m_tready;
  assign s3_final = (s3_idx == nb_m1);
  assign s3_ready = !s3_valid || (out_free && s3_final);
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign s_tready = s1_ready;

  // Stage 1: capture the pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && s_tvalid) begin
      for (int c = 0; c < pcp_pkg::NUM_IN_CHANS; c++) begin
        s1_chan[c] <= s_tdata[c*CW +: CW];
      end
      s1_last <= s_tlast;
    end
  end

  // Stage 2: place each channel lane in use
  always_comb begin
    for (int c = 0; c < MAX_CHANNELS; c++) begin
      if (NW'(c) < chans_eff) begin
        placed[c] = place_channel(s1_chan[c], channel_mask[c]);
      end else begin
        placed[c] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      s2_part <= placed;
      s2_last <= s1_last;
    end
  end

  // Stage 3: merge lanes into the pixel word
  always_comb begin
    word_or = '0;
    for (int c = 0; c < MAX_CHANNELS; c++) begin
      word_or = word_or | s2_part[c];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
      s3_idx   <= '0;
    end else if (s3_ready) begin
      s3_valid <= s2_valid;
      s3_idx   <= '0;
    end else if (out_free) begin
      s3_idx <= s3_idx + BW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && s2_valid) begin
      s3_word <= word_or;
      s3_last <= s2_last;
    end
  end

  // Output register: send one byte of the word per cycle while the output is not stalled
  assign byte_pos = byte_order ? (nb_m1 - s3_idx) : s3_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s3_valid) begin
      m_tdata    <= s3_word[byte_pos*CW +: CW];
      m_tlast    <= s3_final;
      m_tuser[0] <= s3_final && s3_last;
    end
  end

  // Checks
  `PCP_ASSERT_NOW(a_frame_on_pixel_end, m_tvalid && m_tuser[0], m_tlast)
  `PCP_ASSERT_NOW(a_idx_in_range, s3_valid, s3_idx <= nb_m1)
  `PCP_ASSERT_NEXT(a_word_held_midway, s3_valid && out_free && !s3_final,
                   s3_valid && $stable(s3_word))

endmodule

[tb/pixel_channel_packer_tb.sv]
// Self-checking testbench for pixel_channel_packer: masked channel placement and byte streaming.
// Depends on pcp_pkg.sv and the packer RTL; a queue-fed driver and a monitor check each word.
module pixel_channel_packer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CHAN_W         = pcp_pkg::CHAN_W;
  localparam int WORD_W         = pcp_pkg::WORD_W;
  localparam int CNT_W          = pcp_pkg::CNT_W;
  localparam int NUM_IN_CHANS   = pcp_pkg::NUM_IN_CHANS;
  localparam int CFG_INDEX_W    = pcp_pkg::CFG_INDEX_W;
  localparam int CFG_DATA_W     = pcp_pkg::CFG_DATA_W;
  localparam int PIXEL_CHANS    = pcp_pkg::MAX_CHANNELS_DEF;
  localparam int MAX_BYTES      = WORD_W / 8;
  localparam int ALIGN_BIT      = pcp_pkg::CHAN_TOP;
  localparam int HOLD_CYCLES    = 120;
  localparam int DRAIN_CYCLES   = 10;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_PHASES  = 12;
  localparam int PHASE_PIXELS   = 34;
  localparam int MAX_REPORTS    = 10;
  // index past the last register; writes to it must be ignored
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 3'd7;

  typedef struct packed {
    logic [NUM_IN_CHANS*CHAN_W-1:0] chans;
    logic                           last;
  } pixel_t;

  typedef struct packed {
    logic [CHAN_W-1:0] data;
    logic              pixel_end;
    logic              frame_end;
  } out_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [NUM_IN_CHANS*CHAN_W-1:0] s_tdata = '0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [CHAN_W-1:0] m_tdata;
  logic m_tlast;
  logic [0:0] m_tuser;
  logic cfg_wr_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predictor copy of the format registers
  logic              fmt_msb_first = pcp_pkg::BYTE_ORDER_RST;
  logic [CNT_W-1:0]  fmt_bytes     = pcp_pkg::BPP_RST;
  logic [CNT_W-1:0]  fmt_chans     = pcp_pkg::CHAN_CNT_RST;
  logic [WORD_W-1:0] fmt_mask [NUM_IN_CHANS] =
    '{pcp_pkg::MASK_0_RST, pcp_pkg::MASK_1_RST, pcp_pkg::MASK_2_RST, pcp_pkg::MASK_3_RST};

  pixel_t    pixel_q[$];
  out_word_t packed_byte_q[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic hold_req = 1'b0;
  int hold_cnt = 0;
  int mismatch_cnt = 0;
  int quiet_cycles = 0;

  pixel_channel_packer #(.MAX_CHANNELS(PIXEL_CHANS)) uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shift a channel so its bit 7 sits on the mask's top bit, then clip to the mask
  function automatic logic [WORD_W-1:0] place_field(input logic [CHAN_W-1:0] value,
                                                    input logic [WORD_W-1:0] mask);
    int hb;
    logic [WORD_W-1:0] wide;
    hb = WORD_W - 1;
    wide = {{(WORD_W-CHAN_W){1'b0}}, value};
    if (mask == '0) return '0;
    while (hb > 0 && !mask[hb]) hb--;
    if (hb >= ALIGN_BIT) return (wide << (hb - ALIGN_BIT)) & mask;
    return (wide >> (ALIGN_BIT - hb)) & mask;
  endfunction

  // Build the pixel word and queue the bytes it should produce
  function automatic void pack_pixel(input logic [NUM_IN_CHANS*CHAN_W-1:0] chans,
                                     input logic last);
    logic [WORD_W-1:0] word;
    int n_ch, n_bytes, pos;
    out_word_t ow;
    word = '0;
    n_ch = (fmt_chans > PIXEL_CHANS) ? PIXEL_CHANS : fmt_chans;
    n_bytes = (fmt_bytes == 0) ? 1 : ((fmt_bytes > MAX_BYTES) ? MAX_BYTES : fmt_bytes);
    for (int i = 0; i < n_ch; i++)
      word |= place_field(chans[CHAN_W*i +: CHAN_W], fmt_mask[i]);
    for (int i = 0; i < n_bytes; i++) begin
      pos = fmt_msb_first ? (n_bytes - 1 - i) : i;
      ow.data = word[8*pos +: 8];
      ow.pixel_end = (i == n_bytes - 1);
      ow.frame_end = (i == n_bytes - 1) && last;
      packed_byte_q.push_back(ow);
    end
  endfunction

  function automatic void apply_reg(input logic [CFG_INDEX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
    case (idx)
      pcp_pkg::CFG_BYTE_ORDER: fmt_msb_first = val[0];
      pcp_pkg::CFG_BPP:        fmt_bytes = val[CNT_W-1:0];
      pcp_pkg::CFG_CHAN_CNT:   fmt_chans = val[CNT_W-1:0];
      pcp_pkg::CFG_MASK_0:     fmt_mask[0] = val;
      pcp_pkg::CFG_MASK_1:     fmt_mask[1] = val;
      pcp_pkg::CFG_MASK_2:     fmt_mask[2] = val;
      pcp_pkg::CFG_MASK_3:     fmt_mask[3] = val;
      default: ;
    endcase
  endfunction

  function automatic logic roll(input int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic logic [CHAN_W-1:0] rand_chan();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return CHAN_W'($urandom);
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] rand_mask();
    int w, lsb;
    logic [63:0] field;
    w = $urandom_range(1, WORD_W);
    lsb = $urandom_range(0, WORD_W - w);
    field = ((64'd1 << w) - 1) << lsb;
    case ($urandom_range(0, 6))
      0: return '0;
      1: return '1;
      2: return WORD_W'((64'd1 << $urandom_range(1, 7)) - 1);   // top bit below 7
      3: return WORD_W'(64'd1 << $urandom_range(0, WORD_W - 1));
      4: return $urandom;
      default: return field[WORD_W-1:0];
    endcase
  endfunction

  function automatic void add_pixel(input logic [CHAN_W-1:0] c0, c1, c2, c3,
                                    input logic last);
    pixel_t p;
    p.chans = {c3, c2, c1, c0};
    p.last = last;
    pixel_q.push_back(p);
  endfunction

  // Call at a rising edge; the write lands on the next one
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    apply_reg(idx, val);
  endtask

  task automatic set_format(input logic order, input logic [CNT_W-1:0] n_bytes,
                            input logic [CNT_W-1:0] n_chans,
                            input logic [WORD_W-1:0] m0, m1, m2, m3,
                            input logic junk_write);
    // upper data bits of the narrow registers are noise and must not matter
    write_reg(pcp_pkg::CFG_BYTE_ORDER, {31'($urandom), order});
    write_reg(pcp_pkg::CFG_BPP, {29'($urandom), n_bytes});
    write_reg(pcp_pkg::CFG_CHAN_CNT, {29'($urandom), n_chans});
    write_reg(pcp_pkg::CFG_MASK_0, m0);
    write_reg(pcp_pkg::CFG_MASK_1, m1);
    write_reg(pcp_pkg::CFG_MASK_2, m2);
    write_reg(pcp_pkg::CFG_MASK_3, m3);
    if (junk_write) write_reg(CFG_UNUSED, $urandom);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Hold until every pixel went in and every byte came out, then let the pipe settle
  task automatic wait_drained();
    do @(negedge clk);
    while (pixel_q.size() != 0 || s_tvalid || packed_byte_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Driver: predict on accept, then offer the next pending pixel or idle
  always @(posedge clk) begin
    pixel_t p;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) pack_pixel(s_tdata, s_tlast);
      if (!s_tvalid || s_tready) begin
        if (pixel_q.size() != 0 && !roll(send_idle_pct)) begin
          p = pixel_q.pop_front();
          s_tdata <= p.chans;
          s_tlast <= p.last;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here
  always @(posedge clk) begin
    if (hold_req) hold_cnt <= HOLD_CYCLES;
    else if (hold_cnt != 0) hold_cnt <= hold_cnt - 1;
  end

  // Monitor: compare each output word against the oldest predicted byte
  always @(posedge clk) begin
    out_word_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (packed_byte_q.size() == 0) begin
          if (mismatch_cnt < MAX_REPORTS)
            $display("unexpected word: byte %02h last %0b user %0b", m_tdata, m_tlast, m_tuser);
          mismatch_cnt <= mismatch_cnt + 1;
        end else begin
          want = packed_byte_q.pop_front();
          if (m_tdata !== want.data || m_tlast !== want.pixel_end ||
              m_tuser[0] !== want.frame_end) begin
            if (mismatch_cnt < MAX_REPORTS)
              $display("mismatch: byte %02h/%02h last %0b/%0b user %0b/%0b (expected/actual)",
                       want.data, m_tdata, want.pixel_end, m_tlast, want.frame_end, m_tuser);
            mismatch_cnt <= mismatch_cnt + 1;
          end
        end
      end
      m_tready <= (hold_cnt == 0) && !roll(recv_idle_pct);
    end
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct <= 36;
    recv_idle_pct <= 52;

    // Reset format: three 8-bit channels into 24 bits, low byte first
    @(posedge clk);
    @(negedge clk);
    add_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    add_pixel(8'hff, 8'hff, 8'hff, 8'hff, 1'b1);
    add_pixel(8'haa, 8'h55, 8'h80, 8'h01, 1'b0);
    add_pixel(8'h01, 8'h80, 8'h7f, 8'hfe, 1'b1);
    wait_drained();

    // 565 layout plus an alpha byte, most significant byte first
    set_format(1'b1, 3'd4, 3'd4, 32'h0000_f800, 32'h0000_07e0, 32'h0000_001f,
               32'hff00_0000, 1'b0);
    @(negedge clk);
    add_pixel(8'hff, 8'hff, 8'hff, 8'hff, 1'b0);
    add_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
    add_pixel(8'h84, 8'h41, 8'h1f, 8'hc3, 1'b0);
    add_pixel(8'h7b, 8'hbe, 8'he0, 8'h3c, 1'b1);
    wait_drained();

    // No channels and a zero byte count; the unused index must change nothing
    set_format(1'b0, 3'd0, 3'd0, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
               32'hffff_ffff, 1'b1);
    @(negedge clk);
    add_pixel(8'hff, 8'hff, 8'hff, 8'hff, 1'b1);
    add_pixel(8'h5a, 8'ha5, 8'h3c, 8'hc3, 1'b0);
    wait_drained();

    // Oversized counts; empty mask, masks topping out below bit 7, full-word mask
    set_format(1'b1, 3'd7, 3'd7, 32'h0000_0000, 32'h0000_0007, 32'h0000_0001,
               32'hffff_ffff, 1'b1);
    @(negedge clk);
    add_pixel(8'hff, 8'hff, 8'hff, 8'hff, 1'b1);
    add_pixel(8'h80, 8'hc0, 8'h7f, 8'h81, 1'b0);
    add_pixel(8'h40, 8'h20, 8'h80, 8'h01, 1'b1);
    wait_drained();

    // Single byte, single channel at the top bit; then counts one above the legal maximum
    set_format(1'b0, 3'd1, 3'd1, 32'h8000_0000, 32'h0000_00ff, 32'h0000_00ff,
               32'h0000_00ff, 1'b0);
    @(negedge clk);
    add_pixel(8'hff, 8'h12, 8'h34, 8'h56, 1'b0);
    add_pixel(8'h7f, 8'hff, 8'hff, 8'hff, 1'b1);
    wait_drained();
    set_format(1'b0, 3'd5, 3'd5, 32'h0000_00ff, 32'h0000_ff00, 32'h00ff_0000,
               32'hff00_0000, 1'b0);
    @(negedge clk);
    add_pixel(8'h11, 8'h22, 8'h33, 8'h44, 1'b1);
    add_pixel(8'hee, 8'hdd, 8'hcc, 8'hbb, 1'b0);
    wait_drained();

    // Random formats and pixels, three idling patterns
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == RANDOM_PHASES / 3) begin
        send_idle_pct <= 52;
        recv_idle_pct <= 36;
      end else if (ph == 2 * RANDOM_PHASES / 3) begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
      end
      set_format(1'($urandom_range(0, 1)),
                 ($urandom_range(0, 3) == 0) ? CNT_W'($urandom_range(0, 7))
                                             : CNT_W'($urandom_range(1, 4)),
                 ($urandom_range(0, 3) == 0) ? CNT_W'($urandom_range(0, 7))
                                             : CNT_W'($urandom_range(1, 4)),
                 rand_mask(), rand_mask(), rand_mask(), rand_mask(),
                 $urandom_range(0, 2) == 0);
      @(negedge clk);
      for (int i = 0; i < PHASE_PIXELS; i++)
        add_pixel(rand_chan(), rand_chan(), rand_chan(), rand_chan(),
                  $urandom_range(0, 5) == 0);
      // stall the output while input keeps coming so the pipeline backs up
      if (ph == 2 * RANDOM_PHASES / 3) begin
        @(posedge clk);
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
      end
      wait_drained();
    end

    if (mismatch_cnt == 0 && packed_byte_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/pcp_pkg.sv
src/pixel_channel_packer.sv
tb/pixel_channel_packer_tb.sv
